// ===== hdl/qwgs_pkg.sv =====
// ----------------------------------------------------------------------------
// qwgs_pkg
// Shared constants, types and controller commands for the walking gait
// sequencer.
// ----------------------------------------------------------------------------
package qwgs_pkg;

  localparam int unsigned PHASE_PARTS = 6;
  localparam int unsigned Q16_ONE     = 65536;
  localparam logic [18:0] PHASE_WRAP  = 19'(PHASE_PARTS * Q16_ONE);

  // Q.16 constants for foot positions.
  localparam logic signed [17:0] C_0P4     = 18'sd26214;
  localparam logic signed [17:0] C_0P9     = 18'sd58982;
  localparam logic signed [17:0] C_1P4     = 18'sd91750;
  localparam logic signed [17:0] REACH_MIN = -18'sd131071 - 18'sd1;

  // Register reset values.
  localparam logic [11:0] GAIN_RST  = 12'd768;
  localparam logic [15:0] BELLY_RST = 16'd19661;
  localparam logic [15:0] LIFT_RST  = 16'd9830;
  localparam logic signed [16:0] HEIGHT_RST = -17'sd19661;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SPEED_GAIN   = 2'd0;
  localparam logic [1:0] CFG_BELLY_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_LEG_LIFT     = 2'd2;

  // Leg order of the foot state.
  localparam int unsigned LEG_RF = 0;
  localparam int unsigned LEG_RB = 1;
  localparam int unsigned LEG_LF = 2;
  localparam int unsigned LEG_LB = 3;

  // Gait parts, named by what the legs do.
  localparam logic [2:0] PART_SWING_LB = 3'd0;
  localparam logic [2:0] PART_SWING_LF = 3'd1;
  localparam logic [2:0] PART_SHIFT_A  = 3'd2;
  localparam logic [2:0] PART_SWING_RB = 3'd3;
  localparam logic [2:0] PART_SWING_RF = 3'd4;
  localparam logic [2:0] PART_SHIFT_B  = 3'd5;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_SCALE  = 2'd0,
    MUL_SQUARE = 2'd1,
    MUL_LIFT   = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     clock_en;
    logic     update_en;
  } ctl_cmd_t;

endpackage

// ===== hdl/qwgs_controller.sv =====
// ----------------------------------------------------------------------------
// qwgs_controller
// Sequences the shared multiplier and the state update for one item and
// holds the output valid flag.
// ----------------------------------------------------------------------------
module qwgs_controller import qwgs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ctl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CLOCK  = 5'b00010,
    S_SQUARE = 5'b00100,
    S_LIFT   = 5'b01000,
    S_UPDATE = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_blocked;

  assign in_stall    = (state != S_IDLE);
  assign out_blocked = out_valid && out_stall;

  always_comb begin
    state_next    = state;
    cmd.mul_en    = 1'b0;
    cmd.mul_sel   = MUL_SCALE;
    cmd.clock_en  = 1'b0;
    cmd.update_en = 1'b0;
    case (state)
      S_IDLE: begin
        // The scale product is taken straight from the input port.
        if (in_valid) begin
          cmd.mul_en = 1'b1;
          state_next = S_CLOCK;
        end
      end
      S_CLOCK: begin
        cmd.clock_en = 1'b1;
        state_next   = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SQUARE;
        state_next  = S_LIFT;
      end
      S_LIFT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LIFT;
        state_next  = S_UPDATE;
      end
      S_UPDATE: begin
        // The foot registers are the output payload, so wait for the slot.
        if (!out_blocked) begin
          cmd.update_en = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.update_en || out_blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_to_update: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> ##4 (state == S_UPDATE))
    else $error("item did not reach the update step on time");

  a_update_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && out_valid && out_stall) |=> (state == S_UPDATE))
    else $error("update left while the output was blocked");

  a_valid_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("output item dropped while stalled");

endmodule

// ===== hdl/qwgs_datapath.sv =====
// ----------------------------------------------------------------------------
// qwgs_datapath
// Configuration registers, shared multiplier, phase clock and foot state.
// ----------------------------------------------------------------------------
module qwgs_datapath import qwgs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ctl_cmd_t            cmd,
  input  logic [15:0]         frame_delta,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic [2:0]          gait_phase,
  output logic [15:0]         forward_step,
  output logic signed [16:0]  foot_y [4],
  output logic signed [17:0]  foot_z [4]
);

  logic [11:0] speed_gain;
  logic [15:0] belly_height;
  logic [15:0] leg_lift;

  logic [16:0] mul_a, mul_b;
  logic [33:0] prod;
  logic [15:0] d_q;
  logic [18:0] phase_clock;

  logic [15:0] t;
  logic [2:0]  part;
  logic [16:0] u_abs;
  logic [16:0] lift_w;
  logic [15:0] d_sat;
  logic [18:0] clk_sum;
  logic [18:0] clk_wrap;

  logic               crossed;
  logic signed [16:0] arc_y;
  logic signed [16:0] stand_y;
  logic signed [17:0] z_back;
  logic signed [17:0] z_front;
  logic [15:0]        shift_step;
  logic [15:0]        lift_step;
  logic [15:0]        step_next;
  logic signed [18:0] slide_diff [4];
  logic signed [17:0] slide_z    [4];
  logic signed [16:0] y_next     [4];
  logic signed [17:0] z_next     [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain   <= GAIN_RST;
      belly_height <= BELLY_RST;
      leg_lift     <= LIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED_GAIN:   speed_gain   <= cfg_data[11:0];
        CFG_BELLY_HEIGHT: belly_height <= cfg_data;
        CFG_LEG_LIFT:     leg_lift     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign t    = phase_clock[15:0];
  assign part = phase_clock[18:16];

  // |2t - 1| in Q.16; the low half folds around the midpoint.
  assign u_abs  = t[15] ? {1'b0, t[14:0], 1'b0} : 17'h10000 - {t, 1'b0};
  // The square is at most one unit, so bit 32 of the product still counts.
  assign lift_w = 17'h10000 - prod[32:16];

  always_comb begin
    case (cmd.mul_sel)
      MUL_SCALE: begin
        mul_a = {1'b0, frame_delta};
        mul_b = {5'b0, speed_gain};
      end
      MUL_SQUARE: begin
        mul_a = u_abs;
        mul_b = u_abs;
      end
      MUL_LIFT: begin
        mul_a = lift_w;
        mul_b = {1'b0, leg_lift};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= {17'b0, mul_a} * {17'b0, mul_b};
    end
  end

  assign d_sat    = (|prod[27:24]) ? 16'hFFFF : prod[23:8];
  assign clk_sum  = phase_clock + {3'b0, d_sat};
  assign clk_wrap = (clk_sum >= PHASE_WRAP) ? clk_sum - PHASE_WRAP : clk_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_clock <= '0;
    end else if (cmd.clock_en) begin
      phase_clock <= clk_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clock_en) begin
      d_q <= d_sat;
    end
  end

  assign crossed    = t < d_q;
  assign arc_y      = $signed({1'b0, prod[31:16]} - {1'b0, belly_height});
  assign stand_y    = $signed(17'd0 - {1'b0, belly_height});
  assign z_back     = $signed({2'b0, t}) - C_1P4;
  assign z_front    = $signed({2'b0, t}) + C_0P4;
  assign shift_step = (crossed ? t : d_q) >> 1;
  assign lift_step  = crossed ? ((d_q - t) >> 1) : 16'd0;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      slide_diff[i] = {foot_z[i][17], foot_z[i]} - $signed({3'b0, shift_step});
      slide_z[i]    = (slide_diff[i] < $signed({REACH_MIN[17], REACH_MIN})) ?
                      REACH_MIN : slide_diff[i][17:0];
    end
  end

  always_comb begin
    y_next    = foot_y;
    z_next    = foot_z;
    step_next = 16'd0;
    case (part) inside
      PART_SWING_LB: begin
        step_next      = lift_step;
        y_next[LEG_RF] = stand_y;  z_next[LEG_RF] = C_0P9;
        y_next[LEG_RB] = stand_y;  z_next[LEG_RB] = -C_0P9;
        y_next[LEG_LF] = stand_y;  z_next[LEG_LF] = C_0P4;
        y_next[LEG_LB] = arc_y;    z_next[LEG_LB] = z_back;
      end
      PART_SWING_RB: begin
        step_next      = lift_step;
        y_next[LEG_RF] = stand_y;  z_next[LEG_RF] = C_0P4;
        y_next[LEG_LF] = stand_y;  z_next[LEG_LF] = C_0P9;
        y_next[LEG_LB] = stand_y;  z_next[LEG_LB] = -C_0P9;
        y_next[LEG_RB] = arc_y;    z_next[LEG_RB] = z_back;
      end
      PART_SWING_LF: begin
        y_next[LEG_RF] = stand_y;  z_next[LEG_RF] = C_0P9;
        y_next[LEG_RB] = stand_y;  z_next[LEG_RB] = -C_0P9;
        y_next[LEG_LB] = stand_y;  z_next[LEG_LB] = -C_0P4;
        y_next[LEG_LF] = arc_y;    z_next[LEG_LF] = z_front;
      end
      PART_SWING_RF: begin
        y_next[LEG_RB] = stand_y;  z_next[LEG_RB] = -C_0P4;
        y_next[LEG_LF] = stand_y;  z_next[LEG_LF] = C_0P9;
        y_next[LEG_LB] = stand_y;  z_next[LEG_LB] = -C_0P9;
        y_next[LEG_RF] = arc_y;    z_next[LEG_RF] = z_front;
      end
      PART_SHIFT_A, PART_SHIFT_B: begin
        // All feet slide back while the body moves forward.
        step_next = shift_step;
        z_next    = slide_z;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      foot_y[LEG_RF] <= HEIGHT_RST;
      foot_y[LEG_RB] <= HEIGHT_RST;
      foot_y[LEG_LF] <= HEIGHT_RST;
      foot_y[LEG_LB] <= HEIGHT_RST;
      foot_z[LEG_RF] <= C_0P4;
      foot_z[LEG_RB] <= -C_0P4;
      foot_z[LEG_LF] <= C_0P9;
      foot_z[LEG_LB] <= -C_0P9;
    end else if (cmd.update_en) begin
      foot_y <= y_next;
      foot_z <= z_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update_en) begin
      gait_phase   <= part;
      forward_step <= step_next;
    end
  end

  a_clock_range: assert property (@(posedge clk) disable iff (rst)
    phase_clock < PHASE_WRAP)
    else $error("phase clock left its range");

  a_front_lift_still: assert property (@(posedge clk) disable iff (rst)
    (cmd.update_en && (part == PART_SWING_LF || part == PART_SWING_RF))
      |=> (forward_step == 16'd0))
    else $error("body moved during a front leg lift");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.update_en |=> (forward_step <= 16'h8000))
    else $error("forward step above half a unit");

endmodule

// ===== hdl/quadruped_walk_gait_sequencer.sv =====
// ----------------------------------------------------------------------------
// quadruped_walk_gait_sequencer
// Six-part walking gait for a four-legged body in Q.16 fixed point.
// ----------------------------------------------------------------------------
//   Channel  Handshake               Payload
//   input    in_valid / in_stall     frame_delta
//   output   out_valid / out_stall   gait_phase, forward_step, 4 x foot y/z
//   config   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Items do not overlap: the input stalls from acceptance until the state update
// is done. One 17x17 multiplier is used three times in turn (time scale, arc
// square, arc height), with a step for the phase clock and one for the update.
// The update waits while a previous result is still stalled on the output.
// Reset is synchronous and restores the registers and foot state at once.
// cfg_ready is always high; writes to index 3 are ignored.
// ----------------------------------------------------------------------------
module quadruped_walk_gait_sequencer import qwgs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        frame_delta,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         gait_phase,
  output logic [15:0]        forward_step,
  output logic signed [16:0] right_front_y,
  output logic signed [17:0] right_front_z,
  output logic signed [16:0] right_back_y,
  output logic signed [17:0] right_back_z,
  output logic signed [16:0] left_front_y,
  output logic signed [17:0] left_front_z,
  output logic signed [16:0] left_back_y,
  output logic signed [17:0] left_back_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  ctl_cmd_t           cmd;
  logic signed [16:0] foot_y [4];
  logic signed [17:0] foot_z [4];

  assign cfg_ready = 1'b1;

  qwgs_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  qwgs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .frame_delta  (frame_delta),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .gait_phase   (gait_phase),
    .forward_step (forward_step),
    .foot_y       (foot_y),
    .foot_z       (foot_z)
  );

  assign right_front_y = foot_y[0];
  assign right_front_z = foot_z[0];
  assign right_back_y  = foot_y[1];
  assign right_back_z  = foot_z[1];
  assign left_front_y  = foot_y[2];
  assign left_front_z  = foot_z[2];
  assign left_back_y   = foot_y[3];
  assign left_back_z   = foot_z[3];

endmodule

// ===== tb/quadruped_walk_gait_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// quadruped_walk_gait_sequencer_tb
// Self-checking bench for the walking gait sequencer. Frame times are fed
// through a stall-throttled driver, and every result is compared field by
// field against an in-bench Q.16 gait predictor. The run covers several
// register settings, including the extremes, and randomly paces both
// channels.
// ----------------------------------------------------------------------------
module quadruped_walk_gait_sequencer_tb import qwgs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam int WRAP_Q16     = 6 * 65536;
  localparam int N_SETTINGS   = 7;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_LEN     = 250;
  localparam int WATCHDOG     = 4000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [2:0]       gait_phase;
    logic [15:0]      forward_step;
    logic [3:0][16:0] foot_y;
    logic [3:0][17:0] foot_z;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] frame_delta = 16'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] gait_phase;
  logic [15:0] forward_step;
  logic signed [16:0] right_front_y;
  logic signed [17:0] right_front_z;
  logic signed [16:0] right_back_y;
  logic signed [17:0] right_back_z;
  logic signed [16:0] left_front_y;
  logic signed [17:0] left_front_z;
  logic signed [16:0] left_back_y;
  logic signed [17:0] left_back_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  quadruped_walk_gait_sequencer u_top (.*);

  // Predictor state and register copies.
  logic [11:0] gain_q;
  logic [15:0] belly_q;
  logic [15:0] lift_q;
  logic [18:0] phase_clk;
  int          foot_y[4];
  int          foot_z[4];

  logic [15:0] tick_q[$];
  pose_t       pose_q[$];
  string       leg_name[4] = '{"right_front", "right_back", "left_front", "left_back"};

  int  n_issued = 0;
  int  n_accepted = 0;
  int  n_results = 0;
  int  n_settings = 0;
  int  errors = 0;
  int  part_hits[6] = '{0, 0, 0, 0, 0, 0};
  int  cycle_cnt = 0;
  int  quiet_cycles = 0;
  bit  in_fire = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void reset_gait();
    gain_q = GAIN_RST;
    belly_q = BELLY_RST;
    lift_q = LIFT_RST;
    phase_clk = '0;
    for (int i = 0; i < 4; i++) foot_y[i] = -int'(BELLY_RST);
    foot_z[LEG_RF] = int'(C_0P4);
    foot_z[LEG_RB] = -int'(C_0P4);
    foot_z[LEG_LF] = int'(C_0P9);
    foot_z[LEG_LB] = -int'(C_0P9);
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [15:0] data);
    case (idx)
      CFG_SPEED_GAIN:   gain_q = data[11:0];
      CFG_BELLY_HEIGHT: belly_q = data;
      CFG_LEG_LIFT:     lift_q = data;
      default: ;
    endcase
  endfunction

  // Swing arc: lift times (1 - (2t-1)^2), measured from belly depth.
  function automatic int arc_height(input logic [15:0] t);
    longint u, sq, lift;
    u = 2 * longint'(t) - 65536;
    sq = (u * u) >>> 16;
    lift = 65536 - sq;
    return int'((lift * longint'(lift_q)) >>> 16) - int'(belly_q);
  endfunction

  function automatic void place_foot(input int leg, input int y, input int z);
    foot_y[leg] = y;
    foot_z[leg] = z;
  endfunction

  function automatic pose_t advance_gait(input logic [15:0] fd);
    pose_t       r;
    logic [31:0] d;
    logic [19:0] sum;
    logic [2:0]  part;
    logic [15:0] t;
    logic [15:0] stp;
    bit          crossed;
    int          z;
    int          stand_y;
    d = (32'(fd) * 32'(gain_q)) >> 8;
    if (d > 32'd65535) d = 32'd65535;
    sum = 20'(phase_clk) + 20'(d);
    if (sum >= 20'(WRAP_Q16)) sum = sum - 20'(WRAP_Q16);
    phase_clk = sum[18:0];
    part = phase_clk[18:16];
    t = phase_clk[15:0];
    crossed = 32'(t) < d;
    stp = '0;
    stand_y = -int'(belly_q);
    case (part)
      PART_SWING_LB, PART_SWING_RB: begin
        // Time that spilled over from the shift part just left.
        stp = crossed ? 16'(d - 32'(t)) : 16'd0;
        stp = stp >> 1;
        if (part == PART_SWING_LB) begin
          place_foot(LEG_RF, stand_y, int'(C_0P9));
          place_foot(LEG_RB, stand_y, -int'(C_0P9));
          place_foot(LEG_LF, stand_y, int'(C_0P4));
          place_foot(LEG_LB, arc_height(t), int'(t) - int'(C_1P4));
        end else begin
          place_foot(LEG_RF, stand_y, int'(C_0P4));
          place_foot(LEG_LF, stand_y, int'(C_0P9));
          place_foot(LEG_LB, stand_y, -int'(C_0P9));
          place_foot(LEG_RB, arc_height(t), int'(t) - int'(C_1P4));
        end
      end
      PART_SWING_LF: begin
        place_foot(LEG_RF, stand_y, int'(C_0P9));
        place_foot(LEG_RB, stand_y, -int'(C_0P9));
        place_foot(LEG_LB, stand_y, -int'(C_0P4));
        place_foot(LEG_LF, arc_height(t), int'(t) + int'(C_0P4));
      end
      PART_SWING_RF: begin
        place_foot(LEG_RB, stand_y, -int'(C_0P4));
        place_foot(LEG_LF, stand_y, int'(C_0P9));
        place_foot(LEG_LB, stand_y, -int'(C_0P9));
        place_foot(LEG_RF, arc_height(t), int'(t) + int'(C_0P4));
      end
      PART_SHIFT_A, PART_SHIFT_B: begin
        stp = (crossed ? t : d[15:0]) >> 1;
        for (int i = 0; i < 4; i++) begin
          z = foot_z[i] - int'(stp);
          if (z < -131072) z = -131072;
          if (z > 131071) z = 131071;
          foot_z[i] = z;
        end
      end
      default: ;
    endcase
    r.gait_phase = part;
    r.forward_step = stp;
    for (int i = 0; i < 4; i++) begin
      r.foot_y[i] = 17'(foot_y[i]);
      r.foot_z[i] = 18'(foot_z[i]);
    end
    return r;
  endfunction

  // Mostly back to back, with short gaps and now and then a long one.
  function automatic int pick_pause(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] random_tick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 16'($urandom);
    if (r < 75) return 16'($urandom_range(0, 4095));
    if (r < 85) return 16'($urandom_range(0, 255));
    if (r < 91) return 16'd0;
    if (r < 96) return 16'hFFFF;
    return 16'($urandom_range(20000, 23000));
  endfunction

  // Frame time driver.
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (tick_q.size() != 0) begin
        frame_delta <= tick_q.pop_front();
        in_valid <= 1'b1;
        gap_left = pick_pause(cycle_cnt[9:8] == 2'd3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver pacing, with one long hold-off to fill the block.
  always @(negedge clk) begin
    if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_left = pick_pause(cycle_cnt[10:9] == 2'd1);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Monitor: checks results, predicts accepted items, runs the watchdog.
  always @(posedge clk) begin
    pose_t want, got;
    bit    out_fire;
    cycle_cnt++;
    in_fire = !rst && in_valid && !in_stall;
    out_fire = !rst && out_valid && !out_stall;
    if (out_fire) begin
      got.gait_phase = gait_phase;
      got.forward_step = forward_step;
      got.foot_y[LEG_RF] = right_front_y;
      got.foot_z[LEG_RF] = right_front_z;
      got.foot_y[LEG_RB] = right_back_y;
      got.foot_z[LEG_RB] = right_back_z;
      got.foot_y[LEG_LF] = left_front_y;
      got.foot_z[LEG_LF] = left_front_z;
      got.foot_y[LEG_LB] = left_back_y;
      got.foot_z[LEG_LB] = left_back_z;
      if (pose_q.size() == 0) begin
        $error("result with no pending tick: gait_phase %0d", got.gait_phase);
        errors++;
      end else begin
        want = pose_q.pop_front();
        n_results++;
        if (want.gait_phase < 3'd6) part_hits[want.gait_phase]++;
        if (got.gait_phase !== want.gait_phase) begin
          $error("gait_phase: expected %0d, got %0d", want.gait_phase, got.gait_phase);
          errors++;
        end
        if (got.forward_step !== want.forward_step) begin
          $error("forward_step: expected %0d, got %0d", want.forward_step, got.forward_step);
          errors++;
        end
        for (int i = 0; i < 4; i++) begin
          if (got.foot_y[i] !== want.foot_y[i]) begin
            $error("%s_y: expected %0d, got %0d", leg_name[i],
                   $signed(want.foot_y[i]), $signed(got.foot_y[i]));
            errors++;
          end
          if (got.foot_z[i] !== want.foot_z[i]) begin
            $error("%s_z: expected %0d, got %0d", leg_name[i],
                   $signed(want.foot_z[i]), $signed(got.foot_z[i]));
            errors++;
          end
        end
      end
    end
    if (in_fire) begin
      pose_q.push_back(advance_gait(frame_delta));
      n_accepted++;
    end
    if (in_fire || out_fire || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (n_accepted != n_issued || pose_q.size() != 0);
  endtask

  task automatic queue_tick(input logic [15:0] fd);
    tick_q.push_back(fd);
    n_issued++;
  endtask

  initial begin
    logic [15:0] gain_set[N_SETTINGS];
    logic [15:0] belly_set[N_SETTINGS];
    logic [15:0] lift_set[N_SETTINGS];
    int          count_set[N_SETTINGS];
    logic [15:0] directed[20];
    // The first setting keeps the reset values; the wide gain value checks
    // that bits above twelve are dropped.
    gain_set  = '{16'd768, 16'hFFFF, 16'd0, 16'd64, 16'd256, 16'd0, 16'd768};
    belly_set = '{16'd19661, 16'hFFFF, 16'd0, 16'd0, 16'd32768, 16'd0, 16'd19661};
    lift_set  = '{16'd9830, 16'hFFFF, 16'd0, 16'hFFFF, 16'd16384, 16'd0, 16'd9830};
    count_set = '{305, 305, 40, 305, 305, 305, 305};
    directed  = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'h5556,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'h00FF, 16'h7FFF, 16'hAAAA, 16'h0100, 16'hFFFF, 16'h0000,
                  16'h1234, 16'hFFFF};
    reset_gait();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed ticks under reset settings walk through every gait part,
    // with saturated time, zero time and exact part boundaries.
    foreach (directed[i]) queue_tick(directed[i]);
    wait_idle();

    for (int p = 0; p < N_SETTINGS; p++) begin
      if (p == 5) begin
        gain_set[p] = 16'($urandom);
        belly_set[p] = 16'($urandom);
        lift_set[p] = 16'($urandom);
      end
      if (p != 0) begin
        if (p == 6) write_reg(CFG_UNUSED, 16'($urandom));
        write_reg(CFG_SPEED_GAIN, gain_set[p]);
        write_reg(CFG_BELLY_HEIGHT, belly_set[p]);
        write_reg(CFG_LEG_LIFT, lift_set[p]);
        @(negedge clk);
        cfg_valid <= 1'b0;
      end
      n_settings++;
      for (int i = 0; i < count_set[p]; i++) queue_tick(random_tick());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Summary: %0d ticks, %0d results checked over %0d register settings",
             n_accepted, n_results, n_settings);
    $display("Summary: parts hit %0d/%0d/%0d/%0d/%0d/%0d, one %0d-cycle output hold-off",
             part_hits[0], part_hits[1], part_hits[2], part_hits[3], part_hits[4],
             part_hits[5], HOLD_LEN);
    if (errors == 0 && pose_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/qwgs_pkg.sv
hdl/qwgs_controller.sv
hdl/qwgs_datapath.sv
hdl/quadruped_walk_gait_sequencer.sv
tb/quadruped_walk_gait_sequencer_tb.sv
